@@ rtl/sortable_array_store_core_defines.svh @@
// Assertion macros used by the checker file of the sortable array store.
// Depends on a clock named clock and an active-high reset named reset in scope.
`ifndef SORTABLE_ARRAY_STORE_CORE_DEFINES_SVH
`define SORTABLE_ARRAY_STORE_CORE_DEFINES_SVH

// same-cycle implication
`define SAS_ASSERT_SAME(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define SAS_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/sas_pkg.sv @@
// Shared types and constants of the sortable array store.
// No dependencies.
package sas_pkg;

   localparam int OP_W       = 2;
   localparam int INDEX_W    = 6;
   localparam int DATA_W     = 32;
   localparam int STATUS_W   = 2;
   localparam int FILL_W     = 7;
   localparam int GROUP_SIZE = 8;

   localparam logic [OP_W-1:0] OP_APPEND  = 2'd0;
   localparam logic [OP_W-1:0] OP_GET     = 2'd1;
   localparam logic [OP_W-1:0] OP_REPLACE = 2'd2;
   localparam logic [OP_W-1:0] OP_SORT    = 2'd3;

   localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] ST_RANGE = 2'd1;
   localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

   typedef enum logic [1:0] {
      S_IDLE,
      S_READ,
      S_SORT,
      S_DONE
   } state_type;

   // broadcast control to every cell of the row
   typedef struct packed {
      logic wr_en;
      logic sort_en;
      logic phase;
      logic descending;
   } ctrl_type;

endpackage

@@ rtl/sortable_array_store_core.sv @@
// Sortable array store: a row of entry cells with append, get, replace, sort.
// Append, replace, out-of-range get, sort of fewer than two: result registered in
// the cycle after the word is taken; one word per cycle while the result side
// keeps up. In-range get: index, cell-group OR and result registered in turn; sort:
// one odd-even transposition phase per cycle; input stalls until the result loads.
// Synchronous reset clears the fill count and selects ascending order.
module sortable_array_store_core #(
   parameter int CAPACITY = 64
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic [sas_pkg::OP_W-1:0]              req_op,
   input  logic [sas_pkg::INDEX_W-1:0]           req_index,
   input  logic signed [sas_pkg::DATA_W-1:0]     req_value,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic signed [sas_pkg::DATA_W-1:0]     rsp_read_value,
   output logic [sas_pkg::STATUS_W-1:0]          rsp_status,
   output logic [sas_pkg::FILL_W-1:0]            rsp_fill_count,
   input  logic                                  csr_wr_en,
   input  logic                                  csr_wr_data
);
   import sas_pkg::*;

   localparam int CNT_W      = $clog2(CAPACITY + 1);
   localparam int CMP_W      = (CNT_W > INDEX_W) ? CNT_W : INDEX_W;
   localparam int NUM_GROUPS = (CAPACITY + GROUP_SIZE - 1) / GROUP_SIZE;
   localparam int PAD_N      = NUM_GROUPS * GROUP_SIZE;

   state_type                 state_ff, state_in;
   logic [CNT_W-1:0]          count_ff, count_in;
   logic [CNT_W-1:0]          round_ff, round_in;
   logic                      desc_ff, desc_in;
   logic [INDEX_W-1:0]        rd_idx_ff, rd_idx_in;
   logic                      is_read_ff, is_read_in;
   logic [DATA_W-1:0]         group_ff [NUM_GROUPS];
   logic [DATA_W-1:0]         group_in [NUM_GROUPS];
   logic                      rsp_valid_ff, rsp_valid_in;
   logic signed [DATA_W-1:0]  rsp_read_value_ff, rsp_read_value_in;
   logic [STATUS_W-1:0]       rsp_status_ff, rsp_status_in;
   logic [FILL_W-1:0]         rsp_fill_count_ff, rsp_fill_count_in;

   logic                      accept;
   logic                      slot_free;
   logic                      full;
   logic                      in_range;
   logic                      sortable;
   logic                      multi;
   logic                      last_round;
   logic                      imm_load;
   logic                      done_load;
   logic [STATUS_W-1:0]       imm_status;
   logic [DATA_W-1:0]         read_or;
   ctrl_type                  ctrl;
   logic [CNT_W-1:0]          wr_addr;

   logic signed [DATA_W-1:0]  cell_value [CAPACITY];
   logic                      cell_swap  [CAPACITY];
   logic signed [DATA_W-1:0]  left_value [CAPACITY];
   logic                      left_swap  [CAPACITY];
   logic signed [DATA_W-1:0]  right_value[CAPACITY];
   logic [DATA_W-1:0]         rd_pad     [PAD_N];

   // ---- cell row ----
   for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
      if (k == 0) begin : g_first
         assign left_value[k] = '0;
         assign left_swap[k]  = 1'b0;
      end else begin : g_mid
         assign left_value[k] = cell_value[k-1];
         assign left_swap[k]  = cell_swap[k-1];
      end
      if (k == CAPACITY - 1) begin : g_last
         assign right_value[k] = '0;
      end else begin : g_inner
         assign right_value[k] = cell_value[k+1];
      end

      sas_cell #(
         .CAPACITY (CAPACITY),
         .POS      (k)
      ) u_cell (
         .clock       (clock),
         .ctrl        (ctrl),
         .count_i     (count_ff),
         .wr_addr     (wr_addr),
         .wr_data     (req_value),
         .rd_idx      (rd_idx_ff),
         .left_value  (left_value[k]),
         .left_swap   (left_swap[k]),
         .right_value (right_value[k]),
         .value       (cell_value[k]),
         .swap        (cell_swap[k]),
         .rd_data     (rd_pad[k])
      );
   end

   for (genvar p = CAPACITY; p < PAD_N; p++) begin : g_pad
      assign rd_pad[p] = '0;
   end

   // read path: OR per group of cells, registered, then OR over groups
   always_comb begin
      for (int g = 0; g < NUM_GROUPS; g++) begin
         group_in[g] = '0;
         for (int c = 0; c < GROUP_SIZE; c++) begin
            group_in[g] = group_in[g] | rd_pad[g*GROUP_SIZE + c];
         end
      end
   end

   always_comb begin
      read_or = '0;
      for (int g = 0; g < NUM_GROUPS; g++) begin
         read_or = read_or | group_ff[g];
      end
   end

   // ---- decode ----
   assign slot_free  = !rsp_valid_ff || rsp_ready;
   assign accept     = req_valid && req_ready;
   assign full       = (count_ff == CNT_W'(CAPACITY));
   assign in_range   = (CMP_W'(req_index) < CMP_W'(count_ff));
   assign sortable   = (count_ff >= CNT_W'(2));
   assign multi      = ((req_op == OP_GET) && in_range) ||
                       ((req_op == OP_SORT) && sortable);
   assign last_round = (round_ff == (count_ff - CNT_W'(1)));

   always_comb begin
      case (req_op)
         OP_APPEND:  imm_status = full ? ST_FULL : ST_OK;
         OP_GET:     imm_status = in_range ? ST_OK : ST_RANGE;
         OP_REPLACE: imm_status = in_range ? ST_OK : ST_RANGE;
         default:    imm_status = ST_OK;
      endcase
   end

   // ---- next state ----
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept && multi) begin
               state_in = (req_op == OP_GET) ? S_READ : S_SORT;
            end
         end
         S_READ: state_in = S_DONE;
         S_SORT: begin
            if (last_round) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (slot_free) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // ---- outputs of the sequencer ----
   always_comb begin
      req_ready       = 1'b0;
      ctrl.wr_en      = 1'b0;
      ctrl.sort_en    = 1'b0;
      ctrl.phase      = round_ff[0];
      ctrl.descending = desc_ff;
      imm_load        = 1'b0;
      done_load       = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready  = slot_free || multi;
            ctrl.wr_en = accept && (((req_op == OP_APPEND) && !full) ||
                                    ((req_op == OP_REPLACE) && in_range));
            imm_load   = accept && !multi;
         end
         S_READ: begin
         end
         S_SORT: begin
            ctrl.sort_en = 1'b1;
         end
         S_DONE: begin
            done_load = slot_free;
         end
         default: begin
         end
      endcase
   end

   assign wr_addr = (req_op == OP_APPEND) ? count_ff : CNT_W'(req_index);

   // ---- datapath next values ----
   always_comb begin
      count_in = count_ff;
      if (accept && (req_op == OP_APPEND) && !full) begin
         count_in = count_ff + CNT_W'(1);
      end
   end

   assign round_in   = (state_ff == S_SORT) ? (round_ff + CNT_W'(1)) : '0;
   assign desc_in    = csr_wr_en ? csr_wr_data : desc_ff;
   assign rd_idx_in  = accept ? req_index : rd_idx_ff;
   assign is_read_in = accept ? (req_op == OP_GET) : is_read_ff;

   always_comb begin
      rsp_valid_in      = rsp_valid_ff && !rsp_ready;
      rsp_read_value_in = rsp_read_value_ff;
      rsp_status_in     = rsp_status_ff;
      rsp_fill_count_in = rsp_fill_count_ff;
      if (imm_load) begin
         rsp_valid_in      = 1'b1;
         rsp_read_value_in = '0;
         rsp_status_in     = imm_status;
         rsp_fill_count_in = FILL_W'(count_in);
      end else if (done_load) begin
         rsp_valid_in      = 1'b1;
         rsp_read_value_in = is_read_ff ? read_or : '0;
         rsp_status_in     = ST_OK;
         rsp_fill_count_in = FILL_W'(count_ff);
      end
   end

   // ---- registers ----
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         round_ff     <= '0;
         desc_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         round_ff     <= round_in;
         desc_ff      <= desc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_idx_ff         <= rd_idx_in;
      is_read_ff        <= is_read_in;
      rsp_read_value_ff <= rsp_read_value_in;
      rsp_status_ff     <= rsp_status_in;
      rsp_fill_count_ff <= rsp_fill_count_in;
      for (int g = 0; g < NUM_GROUPS; g++) begin
         group_ff[g] <= group_in[g];
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_read_value = rsp_read_value_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_fill_count = rsp_fill_count_ff;

endmodule

@@ rtl/sas_cell.sv @@
// One storage cell of the sortable array store: holds one entry, compares it
// with its right neighbor during sort phases. Depends on sas_pkg.
module sas_cell #(
   parameter int CAPACITY = 64,
   parameter int POS      = 0
) (
   input  logic                                   clock,
   input  sas_pkg::ctrl_type                      ctrl,
   input  logic [$clog2(CAPACITY+1)-1:0]          count_i,
   input  logic [$clog2(CAPACITY+1)-1:0]          wr_addr,
   input  logic signed [sas_pkg::DATA_W-1:0]      wr_data,
   input  logic [sas_pkg::INDEX_W-1:0]            rd_idx,
   input  logic signed [sas_pkg::DATA_W-1:0]      left_value,
   input  logic                                   left_swap,
   input  logic signed [sas_pkg::DATA_W-1:0]      right_value,
   output logic signed [sas_pkg::DATA_W-1:0]      value,
   output logic                                   swap,
   output logic [sas_pkg::DATA_W-1:0]            rd_data
);
   import sas_pkg::*;

   localparam int   CNT_W    = $clog2(CAPACITY + 1);
   localparam logic POS_PAR  = 1'(POS % 2);
   localparam logic RD_REACH = (POS < (1 << INDEX_W));

   logic signed [DATA_W-1:0] value_ff;
   logic signed [DATA_W-1:0] value_in;
   logic                     pair_active;
   logic                     rd_hit;

   // this cell is the left half of a pair in the current phase
   assign pair_active = ctrl.sort_en && (ctrl.phase == POS_PAR) &&
                        (CNT_W'(POS + 1) < count_i);
   assign swap = pair_active && (ctrl.descending ? (right_value > value_ff)
                                                 : (value_ff > right_value));

   assign rd_hit  = RD_REACH && (rd_idx == INDEX_W'(POS));
   assign rd_data = rd_hit ? value_ff : '0;
   assign value   = value_ff;

   always_comb begin
      value_in = value_ff;
      if (ctrl.wr_en && (wr_addr == CNT_W'(POS))) begin
         value_in = wr_data;
      end else if (swap) begin
         value_in = right_value;
      end else if (left_swap) begin
         value_in = left_value;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

endmodule

@@ rtl/sas_checker.sv @@
// Port-level checker for sortable_array_store_core, attached by bind.
// Depends on sas_pkg and sortable_array_store_core_defines.svh.
`include "sortable_array_store_core_defines.svh"

module sas_checker #(
   parameter int CAPACITY = 64
) (
   input logic                                  clock,
   input logic                                  reset,
   input logic                                  rsp_valid,
   input logic                                  rsp_ready,
   input logic signed [sas_pkg::DATA_W-1:0]     rsp_read_value,
   input logic [sas_pkg::STATUS_W-1:0]          rsp_status,
   input logic [sas_pkg::FILL_W-1:0]            rsp_fill_count
);
   import sas_pkg::*;

   localparam logic [FILL_W-1:0] CAP_LOW = FILL_W'(CAPACITY);

   `SAS_ASSERT_SAME(a_status_code, rsp_valid,
      (rsp_status == ST_OK) || (rsp_status == ST_RANGE) || (rsp_status == ST_FULL),
      "result status code out of range")

   `SAS_ASSERT_SAME(a_fill_bound, rsp_valid,
      (CAPACITY > 127) || (rsp_fill_count <= CAP_LOW),
      "fill count beyond capacity")

   `SAS_ASSERT_SAME(a_full_count, rsp_valid && (rsp_status == ST_FULL),
      rsp_fill_count == CAP_LOW,
      "store full reported while not at capacity")

   `SAS_ASSERT_SAME(a_read_ok, rsp_valid && (rsp_read_value != '0),
      (rsp_status == ST_OK),
      "read value present on a failed operation")

   `SAS_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready,
      rsp_valid && $stable(rsp_read_value) && $stable(rsp_status) &&
      $stable(rsp_fill_count),
      "stalled result word changed")

endmodule

bind sortable_array_store_core sas_checker #(.CAPACITY(CAPACITY)) u_sas_checker (.*);

@@ verif/tb_sortable_array_store_core.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for sortable_array_store_core: a shadow store predicts every result.
// Depends on sas_pkg and the sortable_array_store_core RTL.
module tb_sortable_array_store_core;
   import sas_pkg::*;

   localparam int STORE_DEPTH    = 64;
   localparam int SETTLE_CYCLES  = 8;
   localparam int DRAIN_CYCLES   = 20;
   localparam int LONG_HOLD_AT   = 150;
   localparam int LONG_HOLD_LEN  = 300;
   localparam int TIMEOUT_CYCLES = 400000;
   localparam int RANDOM_WORDS   = 800;
   localparam int MAX_REPORTS    = 10;

   localparam logic signed [DATA_W-1:0] MIN_VAL = 32'sh8000_0000;
   localparam logic signed [DATA_W-1:0] MAX_VAL = 32'sh7FFF_FFFF;

   typedef struct {
      logic                      is_cfg;
      logic                      cfg_desc;
      logic [OP_W-1:0]           op;
      logic [INDEX_W-1:0]        index;
      logic signed [DATA_W-1:0]  value;
   } req_item_type;

   typedef struct {
      logic signed [DATA_W-1:0]  read_value;
      logic [STATUS_W-1:0]       status;
      logic [FILL_W-1:0]         fill_count;
   } store_rsp_type;

   logic                        clock;
   logic                        reset = 1'b1;
   logic                        req_valid = 1'b0;
   logic                        req_ready;
   logic [OP_W-1:0]             req_op = OP_APPEND;
   logic [INDEX_W-1:0]          req_index = '0;
   logic signed [DATA_W-1:0]    req_value = '0;
   logic                        rsp_valid;
   logic                        rsp_ready = 1'b0;
   logic signed [DATA_W-1:0]    rsp_read_value;
   logic [STATUS_W-1:0]         rsp_status;
   logic [FILL_W-1:0]           rsp_fill_count;
   logic                        csr_wr_en = 1'b0;
   logic                        csr_wr_data = 1'b0;

   // shadow of the store
   logic signed [DATA_W-1:0]    shadow_entries [STORE_DEPTH];
   int                          shadow_count = 0;
   logic                        shadow_descending = 1'b0;

   req_item_type                word_plan_q [$];
   store_rsp_type               store_outcome_q [$];
   int                          plan_fill = 0;

   int                          req_count = 0;
   int                          rsp_count = 0;
   int                          cfg_writes = 0;
   int                          op_hist [4] = '{0, 0, 0, 0};
   int                          range_seen = 0;
   int                          full_seen = 0;
   int                          err_cnt = 0;
   int                          cycle_cnt = 0;
   int                          gap_left = 0;
   int                          quiet_cycles = 0;
   int                          stall_left = 0;
   int                          hold_left = 0;
   logic                        hold_done = 1'b0;

   sortable_array_store_core #(
      .CAPACITY(STORE_DEPTH)
   ) i_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_op         (req_op),
      .req_index      (req_index),
      .req_value      (req_value),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_read_value (rsp_read_value),
      .rsp_status     (rsp_status),
      .rsp_fill_count (rsp_fill_count),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_cnt <= cycle_cnt + 1;
   end

   // ---------------------------------------------------------------- shadow store

   function automatic void sort_shadow_entries();
      logic signed [DATA_W-1:0] a;
      logic signed [DATA_W-1:0] b;
      logic                     swap;
      for (int i = 0; i + 1 < shadow_count; i++) begin
         for (int j = 0; j + 1 < shadow_count - i; j++) begin
            a = shadow_entries[j];
            b = shadow_entries[j + 1];
            // equal entries stay put
            swap = shadow_descending ? (b > a) : (a > b);
            if (swap) begin
               shadow_entries[j]     = b;
               shadow_entries[j + 1] = a;
            end
         end
      end
   endfunction

   function automatic store_rsp_type apply_store_op(logic [OP_W-1:0] op,
                                                    logic [INDEX_W-1:0] idx,
                                                    logic signed [DATA_W-1:0] val);
      store_rsp_type r;
      r.read_value = '0;
      r.status     = ST_OK;
      case (op)
         OP_APPEND: begin
            if (shadow_count >= STORE_DEPTH) begin
               r.status = ST_FULL;
            end else begin
               shadow_entries[shadow_count] = val;
               shadow_count++;
            end
         end
         OP_GET: begin
            if (int'(idx) >= shadow_count) r.status = ST_RANGE;
            else r.read_value = shadow_entries[idx];
         end
         OP_REPLACE: begin
            if (int'(idx) >= shadow_count) r.status = ST_RANGE;
            else shadow_entries[idx] = val;
         end
         default: sort_shadow_entries();
      endcase
      r.fill_count = shadow_count[FILL_W-1:0];
      return r;
   endfunction

   // ---------------------------------------------------------------- word plan

   task automatic add_op(logic [OP_W-1:0] op, int idx, logic signed [DATA_W-1:0] val);
      req_item_type it;
      it.is_cfg   = 1'b0;
      it.cfg_desc = 1'b0;
      it.op       = op;
      it.index    = idx[INDEX_W-1:0];
      it.value    = val;
      word_plan_q.push_back(it);
      if (op == OP_APPEND && plan_fill < STORE_DEPTH) plan_fill++;
   endtask

   task automatic add_cfg(logic desc);
      req_item_type it;
      it.is_cfg   = 1'b1;
      it.cfg_desc = desc;
      it.op       = OP_APPEND;
      it.index    = '0;
      it.value    = '0;
      word_plan_q.push_back(it);
   endtask

   // mix of wide values, small values (to get duplicates) and the extremes
   function automatic logic signed [DATA_W-1:0] pick_value();
      case ($urandom_range(0, 3))
         0: return $urandom_range(0, 16) - 8;
         1: begin
            case ($urandom_range(0, 3))
               0: return MIN_VAL;
               1: return MAX_VAL;
               2: return 0;
               default: return -1;
            endcase
         end
         default: return $urandom;
      endcase
   endfunction

   function automatic int pick_index();
      if (plan_fill > 0 && $urandom_range(0, 2) != 0) return $urandom_range(0, plan_fill - 1);
      return $urandom_range(0, 63);
   endfunction

   task automatic add_random_word();
      int r;
      r = $urandom_range(0, 99);
      if (r < 15) add_op(OP_APPEND, 0, pick_value());
      else if (r < 50) add_op(OP_GET, pick_index(), pick_value());
      else if (r < 80) add_op(OP_REPLACE, pick_index(), pick_value());
      else add_op(OP_SORT, $urandom_range(0, 63), pick_value());
   endtask

   // ---------------------------------------------------------------- driver

   always @(posedge clock) begin : req_driver
      req_item_type  nxt;
      store_rsp_type res;
      logic          v_next;
      logic          w_next;
      if (reset) begin
         req_valid <= 1'b0;
         csr_wr_en <= 1'b0;
         gap_left     = 0;
         quiet_cycles = 0;
      end else begin
         v_next = req_valid;
         w_next = 1'b0;
         // block is quiet when no word is offered and every result is back
         if (req_valid || req_count != rsp_count) quiet_cycles = 0;
         else quiet_cycles = quiet_cycles + 1;

         if (req_valid && req_ready) begin
            res = apply_store_op(req_op, req_index, req_value);
            store_outcome_q.push_back(res);
            op_hist[req_op] = op_hist[req_op] + 1;
            req_count <= req_count + 1;
            v_next   = 1'b0;
            gap_left = ((req_count + 1) % 160 < 40) ? 0 : $urandom_range(0, 9);
         end else if (!req_valid && gap_left > 0) begin
            gap_left = gap_left - 1;
         end

         if (!v_next && gap_left == 0 && word_plan_q.size() > 0) begin
            if (!word_plan_q[0].is_cfg) begin
               nxt = word_plan_q.pop_front();
               req_op    <= nxt.op;
               req_index <= nxt.index;
               req_value <= nxt.value;
               v_next = 1'b1;
            end else if (quiet_cycles >= SETTLE_CYCLES) begin
               nxt = word_plan_q.pop_front();
               csr_wr_data <= nxt.cfg_desc;
               shadow_descending = nxt.cfg_desc;
               cfg_writes = cfg_writes + 1;
               w_next = 1'b1;
            end
         end
         req_valid <= v_next;
         csr_wr_en <= w_next;
      end
   end

   // ---------------------------------------------------------------- monitor

   // one long receiver hold-off so the block backs up and stalls its input
   always @(posedge clock) begin
      if (reset) begin
         hold_left <= 0;
      end else if (rsp_count == LONG_HOLD_AT && !hold_done) begin
         hold_left <= LONG_HOLD_LEN;
         hold_done <= 1'b1;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
      end
   end

   always @(posedge clock) begin : rsp_monitor
      store_rsp_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            rsp_count <= rsp_count + 1;
            if (rsp_status == ST_RANGE) range_seen = range_seen + 1;
            if (rsp_status == ST_FULL) full_seen = full_seen + 1;
            if (store_outcome_q.size() == 0) begin
               err_cnt = err_cnt + 1;
               if (err_cnt <= MAX_REPORTS)
                  $display("[%0t] unexpected result word: value %0d status %0d fill %0d",
                           $realtime, rsp_read_value, rsp_status, rsp_fill_count);
            end else begin
               want = store_outcome_q.pop_front();
               if (rsp_read_value !== want.read_value || rsp_status !== want.status ||
                   rsp_fill_count !== want.fill_count) begin
                  err_cnt = err_cnt + 1;
                  if (err_cnt <= MAX_REPORTS)
                     $display("[%0t] result %0d mismatch: exp value %0d status %0d fill %0d, %s",
                              $realtime, rsp_count, want.read_value, want.status,
                              want.fill_count,
                              $sformatf("got value %0d status %0d fill %0d",
                                        rsp_read_value, rsp_status, rsp_fill_count));
               end
            end
            stall_left = ((rsp_count % 160) >= 80 && (rsp_count % 160) < 120) ? 0
                         : $urandom_range(0, 9);
         end else if (stall_left > 0) begin
            stall_left = stall_left - 1;
         end
         rsp_ready <= (stall_left == 0) && (hold_left == 0);
      end
   end

   // ---------------------------------------------------------------- stimulus and end

   initial begin
      // directed: empty store, single entry, extremes, duplicates, both orders
      add_cfg(1'b0);
      add_op(OP_GET, 0, 0);
      add_op(OP_REPLACE, 63, 5);
      add_op(OP_SORT, 0, 0);
      add_op(OP_APPEND, 0, MIN_VAL);
      add_op(OP_SORT, 0, 0);
      add_op(OP_GET, 0, 0);
      add_op(OP_GET, 1, 0);
      add_op(OP_APPEND, 0, MAX_VAL);
      add_op(OP_APPEND, 0, 0);
      add_op(OP_APPEND, 0, -1);
      add_op(OP_APPEND, 0, MAX_VAL);
      add_op(OP_REPLACE, 4, 1);
      add_op(OP_REPLACE, 5, 7);
      add_op(OP_SORT, 0, 0);
      for (int i = 0; i < 5; i++) add_op(OP_GET, i, 0);
      add_cfg(1'b1);
      add_op(OP_SORT, 0, 0);
      add_op(OP_GET, 0, 0);
      add_op(OP_GET, 4, 0);

      for (int k = 0; k < 4; k++) begin
         add_cfg(k[0] == 1'b0);
         for (int n = 0; n < RANDOM_WORDS / 4; n++) add_random_word();
      end

      // fill up, then append twice more into a full store and sort both ways
      add_cfg(1'b0);
      while (plan_fill < STORE_DEPTH) add_op(OP_APPEND, 0, pick_value());
      add_op(OP_APPEND, 0, MAX_VAL);
      add_op(OP_APPEND, 0, MIN_VAL);
      add_op(OP_SORT, 0, 0);
      add_op(OP_GET, 0, 0);
      add_op(OP_GET, 63, 0);
      add_cfg(1'b1);
      add_op(OP_SORT, 0, 0);
      add_op(OP_GET, 0, 0);
      add_op(OP_GET, 63, 0);

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      while (!(word_plan_q.size() == 0 && !req_valid && !csr_wr_en && req_count == rsp_count))
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (store_outcome_q.size() != 0) begin
         err_cnt = err_cnt + 1;
         $display("%0d results never arrived", store_outcome_q.size());
      end
      $display("Summary: %0d words (append %0d, get %0d, replace %0d, sort %0d), %0d csr writes",
               req_count, op_hist[OP_APPEND], op_hist[OP_GET], op_hist[OP_REPLACE],
               op_hist[OP_SORT], cfg_writes);
      $display("Summary: %0d results checked, %0d out of range, %0d full, %0d mismatches",
               rsp_count, range_seen, full_seen, err_cnt);
      if (err_cnt == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

   initial begin
      wait (cycle_cnt >= TIMEOUT_CYCLES);
      $display("timeout after %0d cycles", cycle_cnt);
      $display("DONE: errors detected");
      $finish;
   end

endmodule
